// ----- rtl/mtdot_pkg.sv -----
// Package: shared constants, codes and types of the memory trace decoder/OS tagger
`timescale 1ns / 1ps
package mtdot_pkg;

  localparam int unsigned DELAY_DEPTH = 3;
  localparam int unsigned NUM_CELLS   = DELAY_DEPTH - 1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [31:0] OS_LIMIT_RST = 32'h0800_0000;
  localparam logic [7:0]  OS_TRAIL_RST = 8'd3;
  localparam logic [7:0]  STARTUP_RST  = 8'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OS_ADDRESS_LIMIT = 2'd0,
    REG_OS_TRAIL_COUNT   = 2'd1,
    REG_STARTUP_OS_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    TK_ACCESS = 2'd0,
    TK_TIME   = 2'd1,
    TK_NOP    = 2'd2,
    TK_BAD    = 2'd3
  } trace_kind_e;

  localparam logic RK_ACCESS = 1'b0;
  localparam logic RK_ERROR  = 1'b1;

  // one held access
  typedef struct packed {
    logic [63:0] acc_time;
    logic [63:0] acc_delta;
    logic [30:0] addr;
    logic        rd;
    logic        os;
  } entry_t;

  // decoded word waiting in front of the delay line
  typedef struct packed {
    logic        is_err;
    logic [63:0] acc_time;
    logic [30:0] addr;
    logic        rd;
    logic        os;
  } dec_t;

endpackage

// ----- rtl/mtdot_cell.sv -----
// One delay line cell: holds an access, shifts toward the head, picks up OS marks
`timescale 1ns / 1ps
module mtdot_cell
  import mtdot_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  logic   mark_i,
  input  logic   valid_i,
  input  entry_t entry_i,
  output logic   valid_o,
  output entry_t entry_o
);

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (shift_i) begin
      valid_d    = valid_i;
      entry_d    = entry_i;
      entry_d.os = entry_i.os | mark_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

// ----- rtl/mtdot_decode.sv -----
// Front stage: word decode, running time, OS countdown and configuration registers
`timescale 1ns / 1ps
module mtdot_decode
  import mtdot_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [63:0]           trace_word_i,
  input  logic                  take_i,
  output logic                  dec_valid_o,
  output dec_t                  dec_o
);

  logic [31:0] limit_q;
  logic [7:0]  trail_q;
  logic [7:0]  cd_q, cd_d, cd_rl;
  logic [63:0] rt_q, rt_d;
  logic        dv_q, dv_d;
  dec_t        dec_q, dec_d;
  logic        accept, hit;
  trace_kind_e kind;

  assign in_ready_o = !dv_q || take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign kind       = trace_kind_e'(trace_word_i[63:62]);
  assign hit        = {1'b0, trace_word_i[30:0]} < limit_q;
  assign cd_rl      = hit ? trail_q : cd_q;

  always_comb begin
    rt_d  = rt_q;
    cd_d  = cd_q;
    dv_d  = take_i ? 1'b0 : dv_q;
    dec_d = dec_q;
    if (accept) begin
      case (kind)
        TK_ACCESS: begin
          rt_d           = rt_q + {44'd0, trace_word_i[51:32]};
          cd_d           = (cd_rl != 8'd0) ? cd_rl - 8'd1 : 8'd0;
          dv_d           = 1'b1;
          dec_d.is_err   = 1'b0;
          dec_d.acc_time = rt_d;
          dec_d.addr     = trace_word_i[30:0];
          dec_d.rd       = trace_word_i[31];
          dec_d.os       = hit || (cd_rl != 8'd0);
        end
        TK_TIME: begin
          rt_d = rt_q + {19'd0, trace_word_i[44:0]};
        end
        TK_BAD: begin
          dv_d         = 1'b1;
          dec_d.is_err = 1'b1;
        end
        default: ;
      endcase
    end
    // a startup count write loads the countdown directly
    if (cfg_we_i && cfg_idx_i == REG_STARTUP_OS_COUNT) begin
      cd_d = cfg_data_i[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= OS_LIMIT_RST;
      trail_q <= OS_TRAIL_RST;
      cd_q    <= STARTUP_RST;
      rt_q    <= 64'd0;
      dv_q    <= 1'b0;
    end else begin
      cd_q <= cd_d;
      rt_q <= rt_d;
      dv_q <= dv_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_OS_ADDRESS_LIMIT: limit_q <= cfg_data_i;
          REG_OS_TRAIL_COUNT:   trail_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q <= dec_d;
  end

  assign dec_valid_o = dv_q;
  assign dec_o       = dec_q;

endmodule

// ----- rtl/memory_trace_decode_os_tagger_top.sv -----
// Top level: decode stage, chain of delay cells and output register
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+-----------------
//  input   | trace_word_i                              | in  | in_valid_i/in_ready_o
//  output  | result_kind_o, access_time_o, is_read_o,  | out | out_valid_o/out_ready_i
//          | byte_address_o, time_delta_o, is_os_o     |     |
//  config  | cfg_idx_i, cfg_data_i                     | in  | cfg_we_i (no wait)
//
// One word per cycle sustained while the output is not stalled. A word is held in
// the decode register, then steps the delay line; the output register is loaded
// whenever a taken word emits a result. The time add and countdown are combinational.
// A stalled output blocks the line only when the step would emit a result.
// Reset clears the running time and all cell valid flags and loads the countdown
// with the startup count; no clearing pass.
`timescale 1ns / 1ps
module memory_trace_decode_os_tagger_top
  import mtdot_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [63:0]           trace_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  result_kind_o,
  output logic [63:0]           access_time_o,
  output logic                  is_read_o,
  output logic [33:0]           byte_address_o,
  output logic [63:0]           time_delta_o,
  output logic                  is_os_o
);

  logic   dec_valid, take, produces, shift, out_free, load;
  dec_t   dec;
  logic   [63:0] prev_q;
  entry_t new_entry;
  logic   cell_v [NUM_CELLS+1];
  entry_t cell_e [NUM_CELLS+1];

  mtdot_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .trace_word_i (trace_word_i),
    .take_i       (take),
    .dec_valid_o  (dec_valid),
    .dec_o        (dec)
  );

  assign out_free = !out_valid_o || out_ready_i;
  assign produces = dec.is_err || cell_v[0];
  assign take     = dec_valid && (!produces || out_free);
  assign shift    = take && !dec.is_err;
  assign load     = take && produces;

  assign new_entry.acc_time  = dec.acc_time;
  assign new_entry.acc_delta = dec.acc_time - prev_q;
  assign new_entry.addr      = dec.addr;
  assign new_entry.rd        = dec.rd;
  assign new_entry.os        = dec.os;

  // slot NUM_CELLS is the incoming access; cell 0 is the oldest
  assign cell_v[NUM_CELLS] = 1'b1;
  assign cell_e[NUM_CELLS] = new_entry;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    mtdot_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .mark_i  (dec.os),
      .valid_i (cell_v[k+1]),
      .entry_i (cell_e[k+1]),
      .valid_o (cell_v[k]),
      .entry_o (cell_e[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= 64'd0;
      out_valid_o <= 1'b0;
    end else begin
      if (shift) begin
        prev_q <= dec.acc_time;
      end
      if (load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (dec.is_err) begin
        result_kind_o  <= RK_ERROR;
        access_time_o  <= 64'd0;
        is_read_o      <= 1'b0;
        byte_address_o <= 34'd0;
        time_delta_o   <= 64'd0;
        is_os_o        <= 1'b0;
      end else begin
        result_kind_o  <= RK_ACCESS;
        access_time_o  <= cell_e[0].acc_time;
        is_read_o      <= cell_e[0].rd;
        byte_address_o <= {cell_e[0].addr, 3'b000};
        time_delta_o   <= cell_e[0].acc_delta;
        is_os_o        <= cell_e[0].os | dec.os;
      end
    end
  end

endmodule
